/* design/lac_pkg.sv */
// ----------------------------------------------------------------------------
// lac_pkg
// Shared constants, register codes and payload types of the light alarm
// conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package lac_pkg;

   // sizes of the averaging window and the led duty
   localparam int WINDOW_LEN = 10;
   localparam int DUTY_BITS  = 13;

   // field widths
   localparam int MV_W       = 12;
   localparam int TIME_W     = 32;
   localparam int DEB_W      = 16;
   localparam int LONG_W     = 16;
   localparam int MUTE_W     = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // window bookkeeping
   localparam int MV_MAX = 4095;
   localparam int SUM_W  = $clog2(WINDOW_LEN * MV_MAX + 1);
   localparam int POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

   // divide by the window length: multiply by a rounded-up reciprocal
   localparam int              AVG_SHIFT  = 24;
   localparam longint unsigned AVG_MUL    = ((64'd1 << AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam int              AVG_MUL_W  = AVG_SHIFT + 1;
   localparam int              AVG_PROD_W = SUM_W + AVG_MUL_W;

   // led scaling range
   localparam logic [MV_W-1:0] SCALE_LO   = 12'd50;
   localparam logic [MV_W-1:0] SCALE_HI   = 12'd3300;
   localparam int              SCALE_SPAN = 3250;

   // duty = m * DUTY_FULL / SCALE_SPAN through a rounded-up reciprocal
   localparam int              DUTY_SHIFT  = 24;
   localparam longint unsigned DUTY_FULL   = (64'd1 << DUTY_BITS) - 1;
   localparam longint unsigned DUTY_MUL    =
      ((DUTY_FULL << DUTY_SHIFT) + SCALE_SPAN - 1) / SCALE_SPAN;
   localparam int              DUTY_MUL_W  = DUTY_BITS + DUTY_SHIFT - 11;
   localparam int              DUTY_PROD_W = MV_W + DUTY_MUL_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MUTE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECAL_BLW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RECAL_ABV  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP    = 3'd5;

   // register reset values
   localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 16'd30;
   localparam logic [LONG_W-1:0] LONG_RST     = 16'd1000;
   localparam logic [MUTE_W-1:0] MUTE_RST     = 20'd30000;
   localparam logic [MV_W-1:0]   BELOW_RST    = 12'd200;
   localparam logic [MV_W-1:0]   ABOVE_RST    = 12'd100;
   localparam logic [MV_W-1:0]   GAP_RST      = 12'd50;

   // threshold reset values
   localparam logic [MV_W-1:0] ON_RST  = 12'd1000;
   localparam logic [MV_W-1:0] OFF_RST = 12'd1200;

   // button event codes
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_LONG  = 2'd2;

   // status codes
   localparam logic [1:0] ST_MUTED  = 2'd0;
   localparam logic [1:0] ST_ALARM  = 2'd1;
   localparam logic [1:0] ST_NEAR   = 2'd2;
   localparam logic [1:0] ST_NORMAL = 2'd3;

   typedef struct packed {
      logic [MV_W-1:0]   sample_mv;
      logic              button_level;
      logic [TIME_W-1:0] now_ms;
   } lac_item_type;

   typedef struct packed {
      logic [DEB_W-1:0]  debounce_ms;
      logic [LONG_W-1:0] long_press_ms;
      logic [MUTE_W-1:0] mute_ms;
      logic [MV_W-1:0]   recal_below_mv;
      logic [MV_W-1:0]   recal_above_mv;
      logic [MV_W-1:0]   min_gap_mv;
   } lac_cfg_type;

   typedef struct packed {
      logic [MV_W-1:0] filtered_mv;
      logic            buzzer_drive;
      logic [1:0]      status;
      logic [1:0]      button_event;
      logic [MV_W-1:0] on_threshold_mv;
      logic [MV_W-1:0] off_threshold_mv;
   } lac_mid_type;

endpackage

`default_nettype wire

/* design/lac_if.sv */
// ----------------------------------------------------------------------------
// lac_if
// Valid/ready channels of the light alarm conditioner: sample input,
// result output and register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface lac_req_if import lac_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MV_W-1:0]   sample_mv;
   logic              button_level;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, sample_mv, button_level, now_ms, input ready);
   modport sink   (input valid, sample_mv, button_level, now_ms, output ready);
endinterface

interface lac_rsp_if import lac_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MV_W-1:0]      filtered_mv;
   logic [DUTY_BITS-1:0] led_duty;
   logic                 buzzer_drive;
   logic [1:0]           status;
   logic [1:0]           button_event;
   logic [MV_W-1:0]      on_threshold_mv;
   logic [MV_W-1:0]      off_threshold_mv;

   modport source (output valid, filtered_mv, led_duty, buzzer_drive, status,
                   button_event, on_threshold_mv, off_threshold_mv, input ready);
   modport sink   (input valid, filtered_mv, led_duty, buzzer_drive, status,
                   button_event, on_threshold_mv, off_threshold_mv, output ready);
endinterface

interface lac_csr_if import lac_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/lac_core.sv */
// ----------------------------------------------------------------------------
// lac_core
// Per-item state update: button debounce and press timing, mute and
// recalibration, moving average window, alarm hysteresis and status.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_core import lac_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire lac_item_type item,
   input  wire lac_cfg_type  cfg,
   output lac_mid_type       result
);

   localparam logic signed [13:0] LO_S  = 14'sd50;
   localparam logic signed [13:0] HI_S  = 14'sd3300;
   localparam logic signed [13:0] MAX_S = 14'sd4095;

   // state registers
   logic [MV_W-1:0]   window_ff [WINDOW_LEN];
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              primed_ff;
   logic [MV_W-1:0]   held_filt_ff;
   logic              button_stable_ff, button_stable_in;
   logic [TIME_W-1:0] last_change_ff, last_change_in;
   logic [TIME_W-1:0] press_start_ff, press_start_in;
   logic              alarm_ff, alarm_in;
   logic              mute_pending_ff, mute_pending_in;
   logic [TIME_W-1:0] mute_end_ff, mute_end_in;
   logic [MV_W-1:0]   on_ff, on_in;
   logic [MV_W-1:0]   off_ff, off_in;

   // working values
   logic [TIME_W-1:0]     elapsed, held, mute_left;
   logic                  take;
   logic [1:0]            ev;
   logic                  pending;
   logic                  muted;
   logic signed [13:0]    on_s, off_s;
   logic [MV_W-1:0]       old_mv;
   logic [AVG_PROD_W-1:0] avg_prod;
   logic [MV_W-1:0]       mv;
   logic [1:0]            status;

   always_comb begin
      // button debounce and release timing
      elapsed          = item.now_ms - last_change_ff;
      held             = item.now_ms - press_start_ff;
      take             = (item.button_level != button_stable_ff) &&
                         (elapsed >= TIME_W'(cfg.debounce_ms));
      ev               = EV_NONE;
      button_stable_in = button_stable_ff;
      last_change_in   = last_change_ff;
      press_start_in   = press_start_ff;
      if (take) begin
         last_change_in   = item.now_ms;
         button_stable_in = item.button_level;
         if (!item.button_level) begin
            press_start_in = item.now_ms;
         end else if (held >= TIME_W'(cfg.long_press_ms)) begin
            ev = EV_LONG;
         end else if (held >= TIME_W'(cfg.debounce_ms)) begin
            ev = EV_SHORT;
         end
      end

      // recalibration limits from the previous filtered value
      on_s  = $signed({2'b00, held_filt_ff}) - $signed({2'b00, cfg.recal_below_mv});
      off_s = $signed({2'b00, held_filt_ff}) + $signed({2'b00, cfg.recal_above_mv});
      if (on_s < LO_S) begin
         on_s = LO_S;
      end
      if (off_s > HI_S) begin
         off_s = HI_S;
      end
      if (off_s <= on_s + $signed({2'b00, cfg.min_gap_mv})) begin
         off_s = on_s + $signed({2'b00, cfg.min_gap_mv});
      end
      if (on_s > MAX_S) begin
         on_s = MAX_S;
      end
      if (off_s > MAX_S) begin
         off_s = MAX_S;
      end

      // press action
      mute_end_in = mute_end_ff;
      pending     = mute_pending_ff;
      on_in       = on_ff;
      off_in      = off_ff;
      if (ev == EV_SHORT) begin
         mute_end_in = item.now_ms + TIME_W'(cfg.mute_ms);
         pending     = 1'b1;
      end else if (ev == EV_LONG) begin
         on_in  = on_s[MV_W-1:0];
         off_in = off_s[MV_W-1:0];
      end

      // moving average, the first sample fills the window
      old_mv = window_ff[pos_ff];
      if (!primed_ff) begin
         sum_in = SUM_W'(item.sample_mv) * SUM_W'(WINDOW_LEN);
         pos_in = '0;
      end else begin
         sum_in = sum_ff - SUM_W'(old_mv) + SUM_W'(item.sample_mv);
         pos_in = (pos_ff == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_ff + 1'b1;
      end
      avg_prod = AVG_PROD_W'(sum_in) * AVG_PROD_W'(AVG_MUL);
      mv       = primed_ff ? avg_prod[AVG_SHIFT +: MV_W] : item.sample_mv;

      // mute expiry, safe against timestamp wrap
      mute_left       = mute_end_in - item.now_ms;
      muted           = pending && (mute_left != '0) && !mute_left[TIME_W-1];
      mute_pending_in = muted;

      // alarm hysteresis
      alarm_in = alarm_ff;
      if (!alarm_ff && (mv < on_in)) begin
         alarm_in = 1'b1;
      end else if (alarm_ff && (mv > off_in)) begin
         alarm_in = 1'b0;
      end

      // status code
      if (muted) begin
         status = ST_MUTED;
      end else if (alarm_in) begin
         status = ST_ALARM;
      end else if ((mv < off_in) && (mv >= on_in)) begin
         status = ST_NEAR;
      end else begin
         status = ST_NORMAL;
      end

      result.filtered_mv      = mv;
      result.buzzer_drive     = alarm_in && !muted;
      result.status           = status;
      result.button_event     = ev;
      result.on_threshold_mv  = on_in;
      result.off_threshold_mv = off_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= '0;
         sum_ff           <= '0;
         primed_ff        <= 1'b0;
         held_filt_ff     <= '0;
         button_stable_ff <= 1'b1;
         last_change_ff   <= '0;
         press_start_ff   <= '0;
         alarm_ff         <= 1'b0;
         mute_pending_ff  <= 1'b0;
         mute_end_ff      <= '0;
         on_ff            <= ON_RST;
         off_ff           <= OFF_RST;
      end else if (step) begin
         pos_ff           <= pos_in;
         sum_ff           <= sum_in;
         primed_ff        <= 1'b1;
         held_filt_ff     <= mv;
         button_stable_ff <= button_stable_in;
         last_change_ff   <= last_change_in;
         press_start_ff   <= press_start_in;
         alarm_ff         <= alarm_in;
         mute_pending_ff  <= mute_pending_in;
         mute_end_ff      <= mute_end_in;
         on_ff            <= on_in;
         off_ff           <= off_in;
      end
   end

   // window entries, only read once primed
   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            if (!primed_ff || (pos_ff == POS_W'(i))) begin
               window_ff[i] <= item.sample_mv;
            end
         end
      end
   end

endmodule

`default_nettype wire

/* design/light_alarm_conditioner_top.sv */
// ----------------------------------------------------------------------------
// light_alarm_conditioner_top
// Light sensor conditioner: button press classifier, moving average,
// led duty scaling and alarm with hysteresis and mute.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one item per transfer: sample in mV, raw button level and
//   a millisecond timestamp. rsp_ch returns exactly one result per item, in
//   order: filtered value, led duty, buzzer drive, status, button event and
//   the current thresholds. csr_ch writes one register per transfer and is
//   always ready; write it only while no item is in flight.
//   The pipeline has three stages: input register, state update (the
//   per-item state loop closes within this stage), led duty multiply. An
//   item's result is valid once it reaches the output register.
//   Throughput is one item per cycle while rsp_ch is ready. A stalled
//   receiver holds the output register; the stages behind it keep filling,
//   and req_ch.ready drops only when all three stages hold items.
//   Reset clears the pipeline, the thresholds go to 1000 / 1200 mV, the
//   button reads released and the registers take their defaults. The
//   window needs no clearing: the first sample after reset fills it.
// ----------------------------------------------------------------------------
`default_nettype none

module light_alarm_conditioner_top import lac_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   lac_req_if.sink   req_ch,
   lac_rsp_if.source rsp_ch,
   lac_csr_if.sink   csr_ch
);

   // configuration registers
   lac_cfg_type cfg_ff;

   // pipeline registers
   logic         v1_ff, v1_in;
   logic         v2_ff, v2_in;
   logic         v3_ff, v3_in;
   lac_item_type item_ff;
   lac_mid_type  mid_ff;
   lac_mid_type  mid_in;
   lac_mid_type  out_ff;
   logic [DUTY_BITS-1:0] duty_ff, duty_in;

   logic move1, move2, ready2, adv3;
   logic accept;
   logic [MV_W-1:0]        mvc;
   logic [DUTY_PROD_W-1:0] duty_prod;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms    <= DEBOUNCE_RST;
         cfg_ff.long_press_ms  <= LONG_RST;
         cfg_ff.mute_ms        <= MUTE_RST;
         cfg_ff.recal_below_mv <= BELOW_RST;
         cfg_ff.recal_above_mv <= ABOVE_RST;
         cfg_ff.min_gap_mv     <= GAP_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_DEBOUNCE:   cfg_ff.debounce_ms    <= csr_ch.data[DEB_W-1:0];
            CSR_LONG_PRESS: cfg_ff.long_press_ms  <= csr_ch.data[LONG_W-1:0];
            CSR_MUTE:       cfg_ff.mute_ms        <= csr_ch.data[MUTE_W-1:0];
            CSR_RECAL_BLW:  cfg_ff.recal_below_mv <= csr_ch.data[MV_W-1:0];
            CSR_RECAL_ABV:  cfg_ff.recal_above_mv <= csr_ch.data[MV_W-1:0];
            CSR_MIN_GAP:    cfg_ff.min_gap_mv     <= csr_ch.data[MV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // stage handshakes
   assign adv3         = !v3_ff || rsp_ch.ready;
   assign move2        = v2_ff && adv3;
   assign ready2       = !v2_ff || adv3;
   assign move1        = v1_ff && ready2;
   assign req_ch.ready = !v1_ff || ready2;
   assign accept       = req_ch.valid && req_ch.ready;

   assign v1_in = accept || (v1_ff && !move1);
   assign v2_in = move1 || (v2_ff && !move2);
   assign v3_in = move2 || (v3_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.sample_mv    <= req_ch.sample_mv;
         item_ff.button_level <= req_ch.button_level;
         item_ff.now_ms       <= req_ch.now_ms;
      end
   end

   // state update, committed when the item moves on
   lac_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (move1),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (mid_in)
   );

   always_ff @(posedge clock) begin
      if (move1) begin
         mid_ff <= mid_in;
      end
   end

   // led duty: clamp to the scale range, then multiply by the reciprocal
   always_comb begin
      mvc = mid_ff.filtered_mv;
      if (mvc < SCALE_LO) begin
         mvc = SCALE_LO;
      end
      if (mvc > SCALE_HI) begin
         mvc = SCALE_HI;
      end
      duty_prod = DUTY_PROD_W'(mvc - SCALE_LO) * DUTY_PROD_W'(DUTY_MUL);
      duty_in   = duty_prod[DUTY_SHIFT +: DUTY_BITS];
   end

   // output register
   always_ff @(posedge clock) begin
      if (move2) begin
         out_ff  <= mid_ff;
         duty_ff <= duty_in;
      end
   end

   assign rsp_ch.valid            = v3_ff;
   assign rsp_ch.filtered_mv      = out_ff.filtered_mv;
   assign rsp_ch.led_duty         = duty_ff;
   assign rsp_ch.buzzer_drive     = out_ff.buzzer_drive;
   assign rsp_ch.status           = out_ff.status;
   assign rsp_ch.button_event     = out_ff.button_event;
   assign rsp_ch.on_threshold_mv  = out_ff.on_threshold_mv;
   assign rsp_ch.off_threshold_mv = out_ff.off_threshold_mv;

endmodule

`default_nettype wire

/* design/lac_checker.sv */
// ----------------------------------------------------------------------------
// lac_checker
// Port-level checks on the light alarm conditioner result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_checker import lac_pkg::*; (
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire logic            buzzer_drive,
   input wire logic [1:0]      status,
   input wire logic [1:0]      button_event,
   input wire logic [MV_W-1:0] on_threshold_mv,
   input wire logic [MV_W-1:0] off_threshold_mv
);

   // a waiting result stays until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // no result straight out of reset
   a_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // buzzer only sounds in the alarm status
   a_buzzer_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && buzzer_drive |-> status == ST_ALARM)
      else $error("buzzer on outside alarm status");

   // thresholds stay ordered and events stay in range
   a_thresholds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> off_threshold_mv >= on_threshold_mv && button_event != 2'd3)
      else $error("threshold order or button event out of range");

endmodule

bind light_alarm_conditioner_top lac_checker u_lac_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .buzzer_drive     (rsp_ch.buzzer_drive),
   .status           (rsp_ch.status),
   .button_event     (rsp_ch.button_event),
   .on_threshold_mv  (rsp_ch.on_threshold_mv),
   .off_threshold_mv (rsp_ch.off_threshold_mv)
);

`default_nettype wire
